// ----- sv/ppg_pkg.sv -----
// Package for the periodic pattern generator: payload and config types,
// controller/datapath command and status structs, register indexes.
// No dependencies.
`default_nettype none

package ppg_pkg;

	// Fixed sizes of the block
	localparam int PATTERN_DEPTH = 16;
	localparam int SIGNAL_BITS   = 2;
	localparam int TIME_BITS     = 32;
	localparam int IDX_W         = $clog2(PATTERN_DEPTH);
	localparam int LEN_W         = 5;
	localparam int STEP_W        = 16;
	localparam int RPT_W         = 16;
	localparam int PERIOD_W      = 20;   // 16 steps * 65535 ticks fits in 20 bits
	localparam int END_W         = PERIOD_W + RPT_W;
	localparam int CNT_W         = 5;
	localparam int WR_IDX_W      = 3;
	localparam int WR_DATA_W     = 32;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	// Item command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Register indexes
	localparam logic [WR_IDX_W-1:0] REG_START_DELAY    = 3'd0;
	localparam logic [WR_IDX_W-1:0] REG_INITIAL_VALUE  = 3'd1;
	localparam logic [WR_IDX_W-1:0] REG_FINAL_VALUE    = 3'd2;
	localparam logic [WR_IDX_W-1:0] REG_PATTERN_WORDS  = 3'd3;
	localparam logic [WR_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
	localparam logic [WR_IDX_W-1:0] REG_REPEAT_COUNT   = 3'd5;
	localparam logic [WR_IDX_W-1:0] REG_STEP_TICKS     = 3'd6;
	localparam logic [WR_IDX_W-1:0] REG_REPEAT_FOREVER = 3'd7;

	typedef struct packed {
		logic        cmd;
		logic [31:0] query_time;
	} item_t;

	typedef struct packed {
		logic [SIGNAL_BITS-1:0] value;
	} result_t;

	// Config as seen by the datapath, length and step already clamped
	typedef struct packed {
		logic [TIME_BITS-1:0]    start_delay;
		logic [SIGNAL_BITS-1:0]  initial_value;
		logic [SIGNAL_BITS-1:0]  final_value;
		logic [31:0]             pattern_words;
		logic [LEN_W-1:0]        pattern_length;
		logic [RPT_W-1:0]        repeat_count;
		logic [STEP_W-1:0]       step_ticks;
		logic                    repeat_forever;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;       // item transfer
		logic       prep;       // elapsed time and period
		logic       mult;       // end of bounded run
		logic       div_step;   // one bit of elapsed % period
		logic       idx_step;   // one bit of remainder / step
		logic [1:0] bit_k;      // quotient bit for idx_step
		logic       load_out;   // write result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- sv/ppg_stream_if.sv -----
// Valid/ready stream interface used for the item and result channels.
// Payload type is given at instantiation (ppg_pkg item_t / result_t).
`default_nettype none

interface ppg_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/ppg_regs.sv -----
// Configuration register file of the pattern generator.
// Decodes the plain write port and clamps length and step; uses ppg_pkg.
`default_nettype none

module ppg_regs import ppg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [WR_IDX_W-1:0]  wr_index,
	input  logic [WR_DATA_W-1:0] wr_data,
	output cfg_t                 cfg
);

	logic [TIME_BITS-1:0]   start_q;
	logic [SIGNAL_BITS-1:0] init_q;
	logic [SIGNAL_BITS-1:0] final_q;
	logic [31:0]            pattern_q;
	logic [LEN_W-1:0]       len_q;
	logic [RPT_W-1:0]       rpt_q;
	logic [STEP_W-1:0]      step_q;
	logic                   forever_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			init_q    <= '0;
			final_q   <= '0;
			pattern_q <= '0;
			len_q     <= LEN_W'(1);
			rpt_q     <= '0;
			step_q    <= STEP_W'(1);
			forever_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_DELAY:    start_q   <= wr_data[TIME_BITS-1:0];
				REG_INITIAL_VALUE:  init_q    <= wr_data[SIGNAL_BITS-1:0];
				REG_FINAL_VALUE:    final_q   <= wr_data[SIGNAL_BITS-1:0];
				REG_PATTERN_WORDS:  pattern_q <= wr_data[31:0];
				REG_PATTERN_LENGTH: len_q     <= wr_data[LEN_W-1:0];
				REG_REPEAT_COUNT:   rpt_q     <= wr_data[RPT_W-1:0];
				REG_STEP_TICKS:     step_q    <= wr_data[STEP_W-1:0];
				REG_REPEAT_FOREVER: forever_q <= wr_data[0];
			endcase
		end
	end

	// Clamp length to 1..depth and step to at least one tick
	always_comb begin
		cfg.start_delay    = start_q;
		cfg.initial_value  = init_q;
		cfg.final_value    = final_q;
		cfg.pattern_words  = pattern_q;
		cfg.repeat_count   = rpt_q;
		cfg.repeat_forever = forever_q;
		if (len_q == '0)
			cfg.pattern_length = LEN_W'(1);
		else if (len_q > LEN_W'(PATTERN_DEPTH))
			cfg.pattern_length = LEN_W'(PATTERN_DEPTH);
		else
			cfg.pattern_length = len_q;
		cfg.step_ticks = (step_q == '0) ? STEP_W'(1) : step_q;
	end

endmodule

`default_nettype wire

// ----- sv/ppg_dpath.sv -----
// Datapath of the pattern generator: tick time, bit-serial restoring
// divider for elapsed % period, step index search, result register. Uses ppg_pkg.
`default_nettype none

module ppg_dpath import ppg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  item_t      item_data,
	output result_t    result_data,
	output logic       result_valid,
	input  logic       result_ready
);

	logic [TIME_BITS-1:0]   tick_time_q;
	logic [TIME_BITS-1:0]   t_q;
	logic [TIME_BITS-1:0]   elapsed_q;
	logic [TIME_BITS-1:0]   dvd_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [END_W-1:0]       end_q;
	logic [PERIOD_W-1:0]    rem_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic [PERIOD_W:0]      trial;
	logic [PERIOD_W-1:0]    step_sh;
	logic                   before_start;
	logic                   after_end;
	logic [SIGNAL_BITS-1:0] pat_val;
	logic [SIGNAL_BITS-1:0] next_val;

	// Divider trial and shifted step for the index search
	assign trial   = {rem_q, dvd_q[TIME_BITS-1]};
	assign step_sh = {{(PERIOD_W-STEP_W){1'b0}}, cfg.step_ticks} << cmd.bit_k;

	// Value selection
	assign before_start = t_q < cfg.start_delay;
	assign after_end    = !cfg.repeat_forever &&
	                      ({{(END_W-TIME_BITS){1'b0}}, elapsed_q} >= end_q);
	assign pat_val      = cfg.pattern_words[{idx_q, 1'b0} +: SIGNAL_BITS];

	always_comb begin
		priority if (before_start)
			next_val = cfg.initial_value;
		else if (after_end)
			next_val = cfg.final_value;
		else
			next_val = pat_val;
	end

	// Control state: tick time and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && item_data.cmd == CMD_TICK && tick_time_q != TIME_MAX)
				tick_time_q <= tick_time_q + TIME_BITS'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			t_q <= (item_data.cmd == CMD_QUERY) ? item_data.query_time[TIME_BITS-1:0]
			                                    : tick_time_q;
		if (cmd.prep) begin
			elapsed_q <= t_q - cfg.start_delay;
			dvd_q     <= t_q - cfg.start_delay;
			period_q  <= {{(PERIOD_W-LEN_W){1'b0}}, cfg.pattern_length} *
			             {{(PERIOD_W-STEP_W){1'b0}}, cfg.step_ticks};
			rem_q     <= '0;
			idx_q     <= '0;
		end
		if (cmd.mult)
			end_q <= {{(END_W-PERIOD_W){1'b0}}, period_q} *
			         {{(END_W-RPT_W){1'b0}}, cfg.repeat_count};
		// one remainder bit per cycle, MSB of the dividend first
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
			if (trial >= {1'b0, period_q})
				rem_q <= PERIOD_W'(trial - {1'b0, period_q});
			else
				rem_q <= trial[PERIOD_W-1:0];
		end
		// quotient < depth, so greedy subtraction of step << k works
		if (cmd.idx_step && rem_q >= step_sh) begin
			rem_q            <= rem_q - step_sh;
			idx_q[cmd.bit_k] <= 1'b1;
		end
		if (cmd.load_out)
			out_q.value <= next_val;
	end

	assign result_data     = out_q;
	assign result_valid    = out_valid_q;
	assign status.out_free = !out_valid_q || result_ready;

	// Checks
	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && item_data.cmd == CMD_TICK && tick_time_q != TIME_MAX)
		|=> tick_time_q == $past(tick_time_q) + TIME_BITS'(1))
		else $error("tick time did not advance");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.idx_step |-> rem_q < period_q)
		else $error("remainder not below period");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- sv/ppg_ctrl.sv -----
// Controller state machine of the pattern generator: sequences one item
// through prep, multiply, divide and index search. Uses ppg_pkg.
`default_nettype none

module ppg_ctrl import ppg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PREP = 6'b000010,
		S_MULT = 6'b000100,
		S_DIV  = 6'b001000,
		S_IDX  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.bit_k = cnt_q[1:0];
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MULT;
			end
			S_MULT: begin
				cmd.mult = 1'b1;
				cnt_d    = CNT_W'(TIME_BITS - 1);
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					cnt_d   = CNT_W'(IDX_W - 1);
					state_d = S_IDX;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			S_IDX: begin
				cmd.idx_step = 1'b1;
				if (cnt_q == '0)
					state_d = S_DONE;
				else
					cnt_d = cnt_q - CNT_W'(1);
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign item_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire

// ----- sv/periodic_pattern_generator_top.sv -----
// Top level of the periodic pattern generator: config registers,
// controller and datapath. Uses ppg_pkg, ppg_stream_if, ppg_regs, ppg_ctrl, ppg_dpath.
//
//  channel   kind          payload                 transfer
//  item      stream sink   cmd, query_time         valid && ready
//  result    stream source value                   valid && ready
//  wr_*      write port    wr_index, wr_data       wr_en high
//
// Item transfers are spaced by the transfer cycle, prep, multiply, the bit-serial
// divider for elapsed % period, the step index search, and a result write.
// The result waits in an output register; the next item is taken meanwhile,
// and a stalled result only holds the result write. Reset is asynchronous.
`default_nettype none

module periodic_pattern_generator_top import ppg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	ppg_stream_if.sink           item,
	ppg_stream_if.source         result,
	input  logic                 wr_en,
	input  logic [WR_IDX_W-1:0]  wr_index,
	input  logic [WR_DATA_W-1:0] wr_data
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;
	item_t      item_data;
	result_t    result_data;

	assign item_data.cmd        = item.payload.cmd;
	assign item_data.query_time = item.payload.query_time;
	assign result.payload.value = result_data.value;

	ppg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	ppg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	ppg_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.item_data    (item_data),
		.result_data  (result_data),
		.result_valid (result.valid),
		.result_ready (result.ready)
	);

endmodule

`default_nettype wire

// ----- sim/tb_periodic_pattern_generator_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for periodic_pattern_generator_top: directed script, then
// randomized register settings with tick and query traffic under random stalls.
// Depends on ppg_pkg, ppg_stream_if and the generator RTL.

module tb_periodic_pattern_generator_top;
	import ppg_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 610;
	localparam int QUIET_ITEMS  = 60;
	localparam int LONG_STALL   = 400;
	localparam int STALL_AT     = 150;
	localparam int END_SETTLE   = 60;
	localparam int CFG_SETTLE   = 4;
	localparam int SCRIPT_ROWS  = 48;

	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [WR_IDX_W-1:0]    reg_index;
		logic                   cmd;
		logic [31:0]            arg;        // register data or query time
		bit                     known;      // value typed in below
		logic [SIGNAL_BITS-1:0] typed;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [WR_IDX_W-1:0]  wr_index;
	logic [WR_DATA_W-1:0] wr_data;

	ppg_stream_if #(.payload_t(item_t))   item_if ();
	ppg_stream_if #(.payload_t(result_t)) result_if ();

	periodic_pattern_generator_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.result   (result_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow of the generator registers and state
	logic [TIME_BITS-1:0]   gen_start;
	logic [SIGNAL_BITS-1:0] gen_init;
	logic [SIGNAL_BITS-1:0] gen_final;
	logic [31:0]            gen_pattern;
	logic [LEN_W-1:0]       gen_len;
	logic [RPT_W-1:0]       gen_rpt;
	logic [STEP_W-1:0]      gen_step;
	logic                   gen_forever;
	logic [TIME_BITS-1:0]   gen_tick_time;

	logic [SIGNAL_BITS-1:0] expected_values [$];
	script_row_t            script_rows [SCRIPT_ROWS];

	int error_count;
	int cycle_count;
	int results_seen;
	int idle_pct;
	bit quiet;
	bit items_since_drain;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_periodic_pattern_generator_top: errors");
		$finish;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Value of the waveform at time t under the shadow registers
	function automatic logic [SIGNAL_BITS-1:0] pattern_value_at(logic [TIME_BITS-1:0] t);
		longint unsigned steps;
		longint unsigned hold;
		longint unsigned period;
		longint unsigned elapsed;
		longint unsigned slot;
		if (t < gen_start)
			return gen_init;
		steps = (gen_len == 0) ? 1 : (gen_len > PATTERN_DEPTH) ? PATTERN_DEPTH : gen_len;
		hold = (gen_step == 0) ? 1 : gen_step;
		period = steps * hold;
		elapsed = t - gen_start;
		// bounded run is over once a full repeat_count of periods has elapsed
		if (!gen_forever && elapsed >= period * gen_rpt)
			return gen_final;
		slot = (elapsed % period) / hold;
		if (slot * SIGNAL_BITS >= 32)
			return '0;
		return gen_pattern[slot*SIGNAL_BITS +: SIGNAL_BITS];
	endfunction

	function automatic script_row_t write_row(logic [WR_IDX_W-1:0] idx, logic [31:0] data);
		script_row_t r;
		r = '{ROW_WRITE, idx, CMD_TICK, data, 1'b0, '0};
		return r;
	endfunction

	function automatic script_row_t item_row(logic c, logic [31:0] t, bit known,
			logic [SIGNAL_BITS-1:0] v);
		script_row_t r;
		r = '{ROW_ITEM, REG_START_DELAY, c, t, known, v};
		return r;
	endfunction

	// Register write; wr_en is lowered by the next item
	task automatic write_register(logic [WR_IDX_W-1:0] idx, logic [WR_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
		REG_START_DELAY:    gen_start   = data[TIME_BITS-1:0];
		REG_INITIAL_VALUE:  gen_init    = data[SIGNAL_BITS-1:0];
		REG_FINAL_VALUE:    gen_final   = data[SIGNAL_BITS-1:0];
		REG_PATTERN_WORDS:  gen_pattern = data[31:0];
		REG_PATTERN_LENGTH: gen_len     = data[LEN_W-1:0];
		REG_REPEAT_COUNT:   gen_rpt     = data[RPT_W-1:0];
		REG_STEP_TICKS:     gen_step    = data[STEP_W-1:0];
		REG_REPEAT_FOREVER: gen_forever = data[0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one item, wait for the transfer, then queue its expected value
	task automatic offer_item(logic c, logic [31:0] t, bit known, logic [SIGNAL_BITS-1:0] v);
		logic [SIGNAL_BITS-1:0] predicted;
		wr_en           <= 1'b0;
		item_if.valid   <= 1'b1;
		item_if.payload <= '{cmd: c, query_time: t};
		do
			@(posedge clk);
		while (!item_if.ready);
		if (c == CMD_QUERY) begin
			predicted = pattern_value_at(t);
		end else begin
			predicted = pattern_value_at(gen_tick_time);
			if (gen_tick_time != TIME_MAX)
				gen_tick_time++;
		end
		expected_values.push_back(known ? v : predicted);
		items_since_drain = 1'b1;
	endtask

	task automatic sender_pause(int cycles);
		item_if.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Wait until every outstanding result has come back
	task automatic drain_results(int settle);
		item_if.valid <= 1'b0;
		while (expected_values.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
		items_since_drain = 1'b0;
	endtask

	// Result side: random backpressure, one long stall, in-order compare
	initial begin : result_sink
		int gap_left;
		int stall_left;
		bit long_stall_done;
		bit rdy;
		logic [SIGNAL_BITS-1:0] want;
		gap_left = 0;
		stall_left = 0;
		long_stall_done = 1'b0;
		results_seen = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready) begin
				results_seen++;
				if (expected_values.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected",
						result_if.payload.value));
				end else begin
					want = expected_values.pop_front();
					if (result_if.payload.value !== want)
						report_mismatch($sformatf("value %0d, expected %0d",
							result_if.payload.value, want));
				end
			end
			// the long stall starts while the sender is offering items
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!long_stall_done && results_seen >= STALL_AT && item_if.valid) begin
				long_stall_done = 1'b1;
				stall_left = LONG_STALL - 1;
				rdy = 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				rdy = 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
				gap_left = $urandom_range(1, 8) - 1;
				rdy = 1'b0;
			end else begin
				rdy = arst_n;
			end
			result_if.ready <= rdy;
		end
	end

	// Stimulus
	initial begin
		logic [31:0]      r_start;
		logic [31:0]      r_pattern;
		logic [31:0]      junk;
		logic [31:0]      qt;
		logic [LEN_W-1:0] r_len;
		logic [STEP_W-1:0] r_step;
		logic [RPT_W-1:0] r_rpt;
		longint unsigned  run_end;
		int               phase_items;
		int               random_sent;
		bit               narrow;

		error_count = 0;
		idle_pct = 0;
		quiet = 1'b0;
		items_since_drain = 1'b0;
		random_sent = 0;

		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= REG_START_DELAY;
		wr_data         <= '0;
		item_if.valid   <= 1'b0;
		item_if.payload <= '0;

		gen_start = '0;
		gen_init = '0;
		gen_final = '0;
		gen_pattern = '0;
		gen_len = LEN_W'(1);
		gen_rpt = '0;
		gen_step = STEP_W'(1);
		gen_forever = 1'b0;
		gen_tick_time = '0;

		script_rows = '{
			// reset state: bounded run of zero repeats gives final value 0
			item_row(CMD_TICK, 32'h0, 1, 2'd0),
			item_row(CMD_QUERY, 32'hFFFF_FFFF, 1, 2'd0),
			// start 10, steps 0,1,2,3 held 2 ticks, 3 passes: run ends at 34
			write_row(REG_START_DELAY, 32'd10),
			write_row(REG_INITIAL_VALUE, 32'd1),
			write_row(REG_FINAL_VALUE, 32'd2),
			write_row(REG_PATTERN_WORDS, 32'hE4E4_E4E4),
			write_row(REG_PATTERN_LENGTH, 32'd4),
			write_row(REG_REPEAT_COUNT, 32'd3),
			write_row(REG_STEP_TICKS, 32'd2),
			write_row(REG_REPEAT_FOREVER, 32'd0),
			item_row(CMD_QUERY, 32'd0, 1, 2'd1),
			item_row(CMD_QUERY, 32'd9, 1, 2'd1),
			item_row(CMD_QUERY, 32'd10, 1, 2'd0),
			item_row(CMD_QUERY, 32'd12, 1, 2'd1),
			item_row(CMD_QUERY, 32'd17, 1, 2'd3),
			item_row(CMD_QUERY, 32'd33, 1, 2'd3),
			item_row(CMD_QUERY, 32'd34, 1, 2'd2),
			item_row(CMD_QUERY, 32'hFFFF_FFFF, 1, 2'd2),
			item_row(CMD_TICK, 32'h0, 1, 2'd1),
			// endless repeat
			write_row(REG_REPEAT_FOREVER, 32'd1),
			item_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 2'd0),
			item_row(CMD_QUERY, 32'd10, 1, 2'd0),
			// zero length and zero step behave as one
			write_row(REG_PATTERN_LENGTH, 32'd0),
			write_row(REG_STEP_TICKS, 32'd0),
			write_row(REG_PATTERN_WORDS, 32'hFFFF_FFFF),
			item_row(CMD_QUERY, 32'd10, 1, 2'd3),
			item_row(CMD_QUERY, 32'd12345, 1, 2'd3),
			// oversize length clamps; run end lies beyond the time range
			write_row(REG_PATTERN_LENGTH, 32'd31),
			write_row(REG_STEP_TICKS, 32'd65535),
			write_row(REG_PATTERN_WORDS, 32'h1B1B_1B1B),
			write_row(REG_START_DELAY, 32'hF000_0000),
			write_row(REG_REPEAT_COUNT, 32'd65535),
			write_row(REG_REPEAT_FOREVER, 32'd0),
			item_row(CMD_QUERY, 32'hFFFF_FFFF, 0, 2'd0),
			item_row(CMD_QUERY, 32'hEFFF_FFFF, 1, 2'd1),
			// zero repeats: final value right from the start tick
			write_row(REG_REPEAT_COUNT, 32'd0),
			write_row(REG_FINAL_VALUE, 32'd3),
			write_row(REG_START_DELAY, 32'd0),
			item_row(CMD_QUERY, 32'd0, 1, 2'd3),
			item_row(CMD_TICK, 32'h0, 1, 2'd3),
			// start at the top of the time range
			write_row(REG_INITIAL_VALUE, 32'd3),
			write_row(REG_FINAL_VALUE, 32'd0),
			write_row(REG_START_DELAY, 32'hFFFF_FFFF),
			write_row(REG_PATTERN_WORDS, 32'd0),
			item_row(CMD_QUERY, 32'hFFFF_FEEE, 1, 2'd3),
			item_row(CMD_QUERY, 32'hFFFF_FFFF, 1, 2'd0),
			item_row(CMD_TICK, 32'h0, 1, 2'd3),
			item_row(CMD_QUERY, 32'hF000_0000, 0, 2'd0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script
		foreach (script_rows[i]) begin
			if (script_rows[i].kind == ROW_WRITE) begin
				if (items_since_drain)
					drain_results(CFG_SETTLE);
				write_register(script_rows[i].reg_index, script_rows[i].arg);
			end else begin
				offer_item(script_rows[i].cmd, script_rows[i].arg,
					script_rows[i].known, script_rows[i].typed);
			end
		end

		// Random phases: new register setting, then a burst of ticks and queries
		while (random_sent < RANDOM_ITEMS) begin
			drain_results(CFG_SETTLE);
			narrow = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 2))
			0:       idle_pct = 0;
			1:       idle_pct = 15;
			default: idle_pct = 40;
			endcase
			if (narrow) begin
				// start close to the tick time so ticks walk through the pattern
				if (gen_tick_time > 10)
					r_start = gen_tick_time - 10 + $urandom_range(0, 40);
				else
					r_start = $urandom_range(0, 40);
				if ($urandom_range(0, 9) == 0)
					r_len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
				else
					r_len = LEN_W'($urandom_range(1, 16));
				r_step = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
				r_rpt = RPT_W'($urandom_range(0, 6));
			end else begin
				case ($urandom_range(0, 3))
				0:       r_start = '0;
				1:       r_start = '1;
				default: r_start = $urandom;
				endcase
				r_len = LEN_W'($urandom_range(0, 31));
				r_step = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
				case ($urandom_range(0, 3))
				0:       r_rpt = '0;
				1:       r_rpt = '1;
				default: r_rpt = RPT_W'($urandom_range(0, 65535));
				endcase
			end
			r_pattern = $urandom;
			// unused upper data bits now and then carry junk
			junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
			write_register(REG_START_DELAY, r_start);
			write_register(REG_INITIAL_VALUE, {junk[29:0], 2'($urandom_range(0, 3))});
			write_register(REG_FINAL_VALUE, {junk[31:2], 2'($urandom_range(0, 3))});
			write_register(REG_PATTERN_WORDS, r_pattern);
			write_register(REG_PATTERN_LENGTH, {junk[26:0], r_len});
			write_register(REG_REPEAT_COUNT, {junk[15:0], r_rpt});
			write_register(REG_STEP_TICKS, {junk[31:16], r_step});
			write_register(REG_REPEAT_FOREVER,
				{junk[30:0], ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0});

			run_end = longint'(r_start) +
				longint'((r_len == 0) ? 1 : (r_len > PATTERN_DEPTH) ? PATTERN_DEPTH : r_len) *
				longint'((r_step == 0) ? 1 : r_step) * longint'(r_rpt);

			phase_items = $urandom_range(8, 40);
			repeat (phase_items) begin
				quiet = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
				if ($urandom_range(0, 9) < 4) begin
					offer_item(CMD_TICK, $urandom, 0, '0);
				end else begin
					case ($urandom_range(0, 7))
					0, 1:    qt = $urandom;
					2:       qt = r_start + $urandom_range(0, 64);
					3:       qt = 32'(run_end) + $urandom_range(0, 4) - 2;
					4:       qt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
					default: qt = gen_tick_time + $urandom_range(0, 20) - 10;
					endcase
					offer_item(CMD_QUERY, qt, 0, '0);
				end
				random_sent++;
				if (!quiet && $urandom_range(0, 99) < idle_pct)
					sender_pause($urandom_range(1, 8));
			end
		end

		drain_results(END_SETTLE);
		if (error_count == 0)
			$display("tb_periodic_pattern_generator_top: clean");
		else
			$display("tb_periodic_pattern_generator_top: errors");
		$finish;
	end

endmodule
